[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising clk_i edge, skip while rst_ni is low.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that ante implies cons in the same cycle.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  `ASSERT_CLK(lbl, (ante) |-> (cons), msg)

`endif

[rtl/idps_pkg.sv]
// ----------------------------------------------------------------------------
// idps_pkg
// Sizes, constants and shared types of the sequential ID probe scorer.
// ----------------------------------------------------------------------------
package idps_pkg;

  localparam int unsigned SLOTS       = 256;
  localparam int unsigned WINDOW      = 16;
  localparam int unsigned ID_BITS     = 32;
  localparam int unsigned HASH_W      = 32;
  localparam int unsigned IN_ID_W     = 32;

  localparam int unsigned PERCENT     = 100;
  localparam int unsigned ALERT_LEVEL = 80;
  localparam int unsigned MIN_HELD    = 4;

  localparam int unsigned SLOT_W      = $clog2(SLOTS);
  localparam int unsigned POS_W       = $clog2(WINDOW);
  localparam int unsigned FILL_W      = $clog2(WINDOW + 1);
  localparam int unsigned PAIR_W      = $clog2(WINDOW);
  localparam int unsigned SCORE_W     = 7;
  localparam int unsigned DIVD_W      = PAIR_W + $clog2(PERCENT + 1);
  localparam int unsigned CNT_W       = $clog2(DIVD_W + 1);
  localparam int unsigned RING_AW     = SLOT_W + POS_W;

  localparam int unsigned IN_DATA_W   = HASH_W + IN_ID_W;
  localparam int unsigned OUT_FIELD_W = SCORE_W + 3;
  localparam int unsigned OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

  typedef struct packed {
    logic [HASH_W-1:0] tag;
    logic [POS_W-1:0]  pos;
    logic [FILL_W-1:0] fill;
  } meta_t;

endpackage

[rtl/idps_slot_table.sv]
// ----------------------------------------------------------------------------
// idps_slot_table
// Per-slot tag, ring position and fill memory with reset-cleared valid bits.
// ----------------------------------------------------------------------------
module idps_slot_table (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        rd_en_i,
  input  logic [idps_pkg::SLOT_W-1:0] rd_addr_i,
  output logic                        rd_valid_o,
  output idps_pkg::meta_t             rd_meta_o,
  input  logic                        wr_en_i,
  input  logic [idps_pkg::SLOT_W-1:0] wr_addr_i,
  input  idps_pkg::meta_t             wr_meta_i
);
  import idps_pkg::*;

  logic [SLOTS-1:0] valid_q;
  logic             rd_valid_q;
  meta_t            meta_mem [SLOTS];
  meta_t            rd_meta_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      meta_mem[wr_addr_i] <= wr_meta_i;
    end
    if (rd_en_i) begin
      rd_meta_q <= meta_mem[rd_addr_i];
    end
  end

  assign rd_valid_o = rd_valid_q;
  assign rd_meta_o  = rd_meta_q;

endmodule

[rtl/idps_ring_mem.sv]
// ----------------------------------------------------------------------------
// idps_ring_mem
// ID history memory, one ring of WINDOW entries per slot, registered read.
// ----------------------------------------------------------------------------
module idps_ring_mem (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [idps_pkg::RING_AW-1:0] waddr_i,
  input  logic [idps_pkg::ID_BITS-1:0] wdata_i,
  input  logic                         re_i,
  input  logic [idps_pkg::RING_AW-1:0] raddr_i,
  output logic [idps_pkg::ID_BITS-1:0] rdata_o
);
  import idps_pkg::*;

  logic [ID_BITS-1:0] ring_mem [SLOTS*WINDOW];
  logic [ID_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      ring_mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= ring_mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/idps_div.sv]
// ----------------------------------------------------------------------------
// idps_div
// Restoring divider, one quotient bit per cycle, for pairs*100/fill.
// ----------------------------------------------------------------------------
module idps_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [idps_pkg::DIVD_W-1:0]  dividend_i,
  input  logic [idps_pkg::FILL_W-1:0]  divisor_i,
  output logic                         done_o,
  output logic [idps_pkg::SCORE_W-1:0] quotient_o
);
  import idps_pkg::*;

  logic              busy_q;
  logic              done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [FILL_W-1:0] rem_q;
  logic [FILL_W-1:0] dvs_q;
  logic [DIVD_W-1:0] quo_q;
  logic [FILL_W:0]   trial;
  logic [FILL_W:0]   diff;
  logic              ge;
  logic [FILL_W-1:0] rem_nx;

  always_comb begin
    trial  = {rem_q, quo_q[DIVD_W-1]};
    diff   = trial - {1'b0, dvs_q};
    ge     = (trial >= {1'b0, dvs_q});
    rem_nx = ge ? diff[FILL_W-1:0] : trial[FILL_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DIVD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvs_q <= divisor_i;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= rem_nx;
      quo_q <= {quo_q[DIVD_W-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q[SCORE_W-1:0];

endmodule

[rtl/sequential_id_probe_scorer_core.sv]
// ----------------------------------------------------------------------------
// sequential_id_probe_scorer_core
// Scores per-session runs of consecutive object IDs and raises alerts.
// ----------------------------------------------------------------------------
//  channel   dir  bits  contents
//  s_axis    in   64    key_hash [31:0], id_value [63:32]
//  m_axis    out  16    score [6:0], scored [7], alert [8], block [9]
//  cfg       in   1     strict_mode, written when cfg_we_i is high
//
//  One item at a time. A zero ID goes straight to the output load, a slot
//  holding fewer than four IDs loads after the slot memory read and write-back,
//  and a scored item takes one slot memory read, one write-back, fill - 1 ring
//  memory reads, a divider start, 11 divider steps and an output load.
//  Reset clears the slot valid bits at once; no sweep is needed.
//  A result held on m_axis stalls the next result, not the next transfer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sequential_id_probe_scorer_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // key_hash [31:0], id_value [63:32]
  input  logic [idps_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // score [6:0], scored [7], alert [8], block [9], zero fill above
  output logic [idps_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                            cfg_we_i,
  input  logic                            cfg_wdata_i
);
  import idps_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_META = 3'd1;
  localparam logic [2:0] ST_WALK = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]            state_q, state_d;
  logic [HASH_W-1:0]     hash_q, hash_d;
  logic [ID_BITS-1:0]    id_q, id_d;
  logic [POS_W-1:0]      pos_q, pos_d;
  logic [FILL_W-1:0]     fill_q, fill_d;
  logic [FILL_W:0]       off_q, off_d;
  logic [ID_BITS-1:0]    prev_q, prev_d;
  logic [PAIR_W-1:0]     pairs_q, pairs_d;
  logic                  rd_vld_q, rd_vld_d;
  logic [SCORE_W-1:0]    score_q, score_d;
  logic                  scored_q, scored_d;
  logic                  alert_q, alert_d;
  logic                  strict_q;
  logic                  m_valid_q;
  logic [OUT_DATA_W-1:0] m_data_q;
  logic                  out_load;

  logic                  meta_re;
  logic                  meta_vld;
  meta_t                 meta_rd;
  logic                  meta_we;
  meta_t                 meta_wr;

  logic                  ring_we;
  logic [RING_AW-1:0]    ring_waddr;
  logic                  ring_re;
  logic [RING_AW-1:0]    ring_raddr;
  logic [ID_BITS-1:0]    ring_rdata;

  logic                  div_start;
  logic                  div_done;
  logic [SCORE_W-1:0]    div_quo;
  logic [DIVD_W-1:0]     dividend;

  logic                  hit;
  logic [POS_W-1:0]      base_pos;
  logic [FILL_W-1:0]     base_fill;
  logic [POS_W-1:0]      new_pos;
  logic [FILL_W-1:0]     new_fill;
  logic                  issue;
  logic [FILL_W:0]       rd_idx;
  logic [PAIR_W-1:0]     pairs_nx;
  logic [ID_BITS-1:0]    in_id;

  function automatic logic differ_by_one(logic [ID_BITS-1:0] a, logic [ID_BITS-1:0] b);
    logic [ID_BITS:0] d_ab;
    logic [ID_BITS:0] d_ba;
    d_ab = {1'b0, a} - {1'b0, b};
    d_ba = {1'b0, b} - {1'b0, a};
    return (d_ab == (ID_BITS+1)'(1)) || (d_ba == (ID_BITS+1)'(1));
  endfunction

  idps_slot_table u_slot_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (meta_re),
    .rd_addr_i  (s_axis_tdata[SLOT_W-1:0]),
    .rd_valid_o (meta_vld),
    .rd_meta_o  (meta_rd),
    .wr_en_i    (meta_we),
    .wr_addr_i  (hash_q[SLOT_W-1:0]),
    .wr_meta_i  (meta_wr)
  );

  idps_ring_mem u_ring_mem (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (ring_waddr),
    .wdata_i (id_q),
    .re_i    (ring_re),
    .raddr_i (ring_raddr),
    .rdata_o (ring_rdata)
  );

  idps_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (fill_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_id         = s_axis_tdata[HASH_W +: ID_BITS];

  always_comb begin
    hit       = meta_vld && (meta_rd.tag == hash_q);
    base_pos  = hit ? meta_rd.pos : '0;
    base_fill = hit ? meta_rd.fill : '0;
    new_pos   = (base_pos == POS_W'(WINDOW - 1)) ? '0 : base_pos + 1'b1;
    new_fill  = (base_fill == FILL_W'(WINDOW)) ? base_fill : base_fill + 1'b1;

    issue  = (state_q == ST_WALK) && (off_q <= {1'b0, fill_q});
    rd_idx = (off_q <= (FILL_W+1)'(pos_q))
           ? (FILL_W+1)'(pos_q) - off_q
           : (FILL_W+1)'(pos_q) + (FILL_W+1)'(WINDOW) - off_q;
    pairs_nx = pairs_q + PAIR_W'(rd_vld_q && differ_by_one(ring_rdata, prev_q));
    dividend = DIVD_W'(pairs_nx) * DIVD_W'(PERCENT);

    meta_wr.tag  = hash_q;
    meta_wr.pos  = new_pos;
    meta_wr.fill = new_fill;
    ring_waddr   = {hash_q[SLOT_W-1:0], base_pos};
    ring_raddr   = {hash_q[SLOT_W-1:0], rd_idx[POS_W-1:0]};

    state_d   = state_q;
    hash_d    = hash_q;
    id_d      = id_q;
    pos_d     = pos_q;
    fill_d    = fill_q;
    off_d     = off_q;
    prev_d    = prev_q;
    pairs_d   = pairs_q;
    rd_vld_d  = 1'b0;
    score_d   = score_q;
    scored_d  = scored_q;
    alert_d   = alert_q;
    meta_re   = 1'b0;
    meta_we   = 1'b0;
    ring_we   = 1'b0;
    ring_re   = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          hash_d = s_axis_tdata[HASH_W-1:0];
          id_d   = in_id;
          if (in_id == '0) begin
            score_d  = '0;
            scored_d = 1'b0;
            alert_d  = 1'b0;
            state_d  = ST_OUT;
          end else begin
            meta_re = 1'b1;
            state_d = ST_META;
          end
        end
      end
      ST_META: begin
        meta_we = 1'b1;
        ring_we = 1'b1;
        pos_d   = new_pos;
        fill_d  = new_fill;
        prev_d  = id_q;
        pairs_d = '0;
        off_d   = (FILL_W+1)'(2);
        if (new_fill < FILL_W'(MIN_HELD)) begin
          score_d  = '0;
          scored_d = 1'b0;
          alert_d  = 1'b0;
          state_d  = ST_OUT;
        end else begin
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        ring_re  = issue;
        rd_vld_d = issue;
        if (issue) begin
          off_d = off_q + 1'b1;
        end
        if (rd_vld_q) begin
          pairs_d = pairs_nx;
          prev_d  = ring_rdata;
          if (!issue) begin
            div_start = 1'b1;
            state_d   = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          score_d  = div_quo;
          scored_d = 1'b1;
          alert_d  = (div_quo >= SCORE_W'(ALERT_LEVEL));
          state_d  = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      rd_vld_q  <= 1'b0;
      strict_q  <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= rd_vld_d;
      if (cfg_we_i) begin
        strict_q <= cfg_wdata_i;
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    hash_q   <= hash_d;
    id_q     <= id_d;
    pos_q    <= pos_d;
    fill_q   <= fill_d;
    off_q    <= off_d;
    prev_q   <= prev_d;
    pairs_q  <= pairs_d;
    score_q  <= score_d;
    scored_q <= scored_d;
    alert_q  <= alert_d;
    if (out_load) begin
      m_data_q <= OUT_DATA_W'({alert_q & strict_q, alert_q, scored_q, score_q});
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  `ASSERT_IMPL(a_alert_needs_level, m_axis_tvalid && m_axis_tdata[SCORE_W+1],
    m_axis_tdata[SCORE_W-1:0] >= SCORE_W'(ALERT_LEVEL), "alert below level")
  `ASSERT_IMPL(a_block_needs_alert, m_axis_tvalid && m_axis_tdata[SCORE_W+2],
    m_axis_tdata[SCORE_W+1], "block without alert")
  `ASSERT_IMPL(a_unscored_is_zero, m_axis_tvalid && !m_axis_tdata[SCORE_W],
    m_axis_tdata[SCORE_W+2:0] == '0, "unscored result not zero")
  `ASSERT_IMPL(a_div_done_in_div, div_done, state_q == ST_DIV,
    "divider finished outside divide phase")

endmodule

[tb/sequential_id_probe_scorer_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequential_id_probe_scorer_core_tb
// Self-checking bench for the sequential ID probe scorer. A queue-fed driver
// sends key hash / object ID pairs in random bursts, and each transfer is
// scored by a local model of the slot table and ID rings. A monitor with its
// own stall pattern checks every result in order. The run covers directed
// edge cases, then interleaved session traffic under both strict-mode values.
// ----------------------------------------------------------------------------
module sequential_id_probe_scorer_core_tb;
  import idps_pkg::*;

  localparam int unsigned N_SESS       = 10;
  localparam int unsigned PHASE_ITEMS  = 335;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned HOLD_AT      = 500;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned IDLE_LIMIT   = 3000;

  typedef struct packed {
    logic               blocked;
    logic               alert;
    logic               scored;
    logic [SCORE_W-1:0] score;
  } verdict_t;

  logic                  clk_i;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_we_i      = 1'b0;
  logic                  cfg_wdata_i   = 1'b0;

  // key_hash [31:0], id_value [63:32]
  logic [IN_DATA_W-1:0] pending_q [$];
  verdict_t             verdict_q [$];

  // local copy of the slot table
  logic [HASH_W-1:0]  slot_key  [SLOTS];
  bit                 slot_live [SLOTS];
  logic [POS_W-1:0]   slot_pos  [SLOTS];
  int unsigned        slot_fill [SLOTS];
  logic [ID_BITS-1:0] id_hist   [SLOTS][WINDOW];
  logic               strict_now = 1'b0;

  logic [HASH_W-1:0]  sess_hash [N_SESS];
  logic [ID_BITS-1:0] sess_id   [N_SESS];
  bit                 sess_dn   [N_SESS];

  int unsigned burst_left, gap_left;
  int unsigned rdy_mode, mode_left, hold_left;
  int unsigned idle_cycles;
  int unsigned items_sent, results_seen, n_scored, n_alert, n_block;
  int unsigned errors;
  verdict_t    got, want;

  sequential_id_probe_scorer_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic verdict_t score_probe(input logic [HASH_W-1:0] hash,
                                           input logic [ID_BITS-1:0] id);
    verdict_t          r;
    logic [SLOT_W-1:0] s;
    logic [POS_W-1:0]  p, ni, oi;
    int unsigned       f, pairs, pct, k;
    r = '0;
    if (id == '0) return r;
    s = hash[SLOT_W-1:0];
    if (!slot_live[s] || slot_key[s] != hash) begin
      slot_live[s] = 1'b1;
      slot_key[s]  = hash;
      slot_pos[s]  = '0;
      slot_fill[s] = 0;
    end
    id_hist[s][slot_pos[s]] = id;
    slot_pos[s] = slot_pos[s] + 1'b1;
    if (slot_fill[s] < WINDOW) slot_fill[s] = slot_fill[s] + 1;
    f = slot_fill[s];
    if (f < MIN_HELD) return r;
    p = slot_pos[s];
    pairs = 0;
    for (k = 1; k < f; k++) begin
      ni = p - POS_W'(k);
      oi = ni - 1'b1;
      if ({1'b0, id_hist[s][ni]} - {1'b0, id_hist[s][oi]} == 33'd1 ||
          {1'b0, id_hist[s][oi]} - {1'b0, id_hist[s][ni]} == 33'd1) pairs++;
    end
    pct       = pairs * PERCENT / f;
    r.score   = pct[SCORE_W-1:0];
    r.scored  = 1'b1;
    r.alert   = (pct >= ALERT_LEVEL);
    r.blocked = r.alert & strict_now;
    return r;
  endfunction

  // driver: bursts with random gaps, scoring each transfer as it happens
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      burst_left     = 1;
      gap_left       = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        verdict_q.push_back(score_probe(s_axis_tdata[HASH_W-1:0],
                                        s_axis_tdata[IN_DATA_W-1:HASH_W]));
        items_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          s_axis_tdata  <= pending_q.pop_front();
          s_axis_tvalid <= 1'b1;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: check results in order, stall on a shifting pattern
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rdy_mode       = 0;
      mode_left      = 0;
      hold_left      = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[OUT_FIELD_W-1:0];
        if (verdict_q.size() == 0) begin
          $error("result with nothing expected: tdata=%h", m_axis_tdata);
          errors++;
        end else begin
          want = verdict_q.pop_front();
          if (got.score !== want.score) begin
            $error("score: expected %0d, actual %0d", want.score, got.score);
            errors++;
          end
          if (got.scored !== want.scored) begin
            $error("scored: expected %0d, actual %0d", want.scored, got.scored);
            errors++;
          end
          if (got.alert !== want.alert) begin
            $error("alert: expected %0d, actual %0d", want.alert, got.alert);
            errors++;
          end
          if (got.blocked !== want.blocked) begin
            $error("block: expected %0d, actual %0d", want.blocked, got.blocked);
            errors++;
          end
        end
        results_seen++;
        n_scored += got.scored;
        n_alert  += got.alert;
        n_block  += got.blocked;
        if (results_seen == HOLD_AT) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          rdy_mode  = $urandom_range(0, 3);
          mode_left = $urandom_range(8, 80);
        end
        mode_left--;
        case (rdy_mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= 1'($urandom_range(0, 1));
          2: m_axis_tready <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready <= mode_left[1];
        endcase
      end
    end
  end

  // watchdog: end the run when nothing transfers for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("sequential_id_probe_scorer_core: mismatch");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic push_probe(input logic [HASH_W-1:0] hash, input logic [ID_BITS-1:0] id);
    pending_q.push_back({id, hash});
  endtask

  task automatic set_strict(input logic v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    strict_now   = v;
  endtask

  task automatic wait_drained();
    @(posedge clk_i);
    while (pending_q.size() != 0 || s_axis_tvalid || verdict_q.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic queue_directed();
    // zero ID on an empty table
    push_probe(32'h0000_0000, 32'd0);
    // run up from one: below four held, then 75, then 80
    push_probe(32'h0000_0000, 32'd1);
    push_probe(32'h0000_0000, 32'd2);
    push_probe(32'h0000_0000, 32'd3);
    push_probe(32'h0000_0000, 32'd4);
    push_probe(32'h0000_0000, 32'd5);
    // zero ID on a live slot leaves it untouched
    push_probe(32'h0000_0000, 32'd0);
    push_probe(32'h0000_0000, 32'd6);
    // top of the ID range, top slot
    push_probe(32'hFFFF_FFFF, 32'hFFFF_FFFC);
    push_probe(32'hFFFF_FFFF, 32'hFFFF_FFFD);
    push_probe(32'hFFFF_FFFF, 32'hFFFF_FFFE);
    push_probe(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_probe(32'hFFFF_FFFF, 32'hFFFF_FFFE);
    // same slot, new tag: evict and restart
    push_probe(32'h0000_0100, 32'd7);
    push_probe(32'h0000_0000, 32'd8);
    // spread-out IDs and repeats score zero; the last two differ by one across bit 31
    push_probe(32'h1234_5601, 32'd10);
    push_probe(32'h1234_5601, 32'd20);
    push_probe(32'h1234_5601, 32'd20);
    push_probe(32'h1234_5601, 32'd40);
    push_probe(32'h1234_5601, 32'h8000_0000);
    push_probe(32'h1234_5601, 32'h7FFF_FFFF);
  endtask

  task automatic queue_sessions(input int unsigned n_items);
    int unsigned       r, k, done;
    logic [HASH_W-1:0] hash, tmp;
    logic [ID_BITS-1:0] id;
    done = 0;
    while (done < n_items) begin
      r = $urandom_range(0, 99);
      k = $urandom_range(0, N_SESS - 1);
      if (r < 5) begin
        hash = $urandom();
        id   = ($urandom_range(0, 3) == 0) ? 32'd0 : 32'($urandom());
      end else if (r < 8) begin
        hash = sess_hash[k];
        id   = 32'd0;
      end else begin
        if (r < 10) begin
          tmp          = $urandom();
          sess_hash[k] = {tmp[HASH_W-1:SLOT_W], sess_hash[k][SLOT_W-1:0]};
        end
        hash = sess_hash[k];
        r    = $urandom_range(0, 99);
        if (r < 80)      id = sess_dn[k] ? sess_id[k] - 1'b1 : sess_id[k] + 1'b1;
        else if (r < 88) id = $urandom();
        else if (r < 92) id = 32'hFFFF_FFFF - $urandom_range(0, 20);
        else if (r < 96) id = $urandom_range(1, 20);
        else             id = sess_id[k];
        if (id != '0) sess_id[k] = id;
        if ($urandom_range(0, 30) == 0) sess_dn[k] = ~sess_dn[k];
      end
      push_probe(hash, id);
      if (id != '0) done++;
    end
  endtask

  initial begin
    for (int s = 0; s < SLOTS; s++) begin
      slot_live[s] = 1'b0;
      slot_pos[s]  = '0;
      slot_fill[s] = 0;
    end
    for (int k = 0; k < N_SESS; k++) begin
      sess_hash[k] = $urandom();
      sess_id[k]   = $urandom_range(1, 1000);
      sess_dn[k]   = 1'($urandom_range(0, 1));
    end
    // two sessions fight over one slot
    sess_hash[1][SLOT_W-1:0] = sess_hash[0][SLOT_W-1:0];
    items_sent   = 0;
    results_seen = 0;
    n_scored     = 0;
    n_alert      = 0;
    n_block      = 0;
    errors       = 0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    set_strict(1'b1);
    queue_directed();
    wait_drained();
    for (int ph = 0; ph < 4; ph++) begin
      set_strict(ph[0]);
      queue_sessions(PHASE_ITEMS);
      wait_drained();
    end

    if (verdict_q.size() != 0) begin
      $error("%0d expected results never arrived", verdict_q.size());
      errors++;
    end
    $display("Sent %0d probes across both strict settings; got %0d results", items_sent,
             results_seen);
    $display("  %0d scored, %0d alerts, %0d blocks, %0d errors", n_scored, n_alert,
             n_block, errors);
    if (errors == 0) begin
      $display("sequential_id_probe_scorer_core: match");
    end else begin
      $display("sequential_id_probe_scorer_core: mismatch");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/idps_pkg.sv
rtl/idps_slot_table.sv
rtl/idps_ring_mem.sv
rtl/idps_div.sv
rtl/sequential_id_probe_scorer_core.sv
tb/sequential_id_probe_scorer_core_tb.sv
